@@ rtl/sound_level_packet_receiver_defines.svh @@
// Assertion helpers for the sound level packet receiver.
// Both sample on clk_i and are held off while rst_ni is low.
`ifndef SOUND_LEVEL_PACKET_RECEIVER_DEFINES_SVH
`define SOUND_LEVEL_PACKET_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
`define SLPR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("slpr assertion failed");
`define SLPR_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("slpr forbidden condition seen");
`else
`define SLPR_ASSERT(name, prop)
`define SLPR_ASSERT_NEVER(name, cond)
`endif

`endif

@@ rtl/slpr_pkg.sv @@
package slpr_pkg;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_MEAS   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_HEADER = 3'd1,
    ERR_MEAS   = 3'd2,
    ERR_SUM    = 3'd3,
    ERR_MODE   = 3'd4,
    ERR_CFG    = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'b01,
    PH_COLLECT = 2'b10
  } phase_e;

  localparam logic [7:0] READY_BYTE = 8'h10;
  localparam logic [7:0] CMD_BYTE   = 8'h20;
  localparam logic [7:0] HDR_BYTE0  = 8'h08;
  localparam logic [7:0] HDR_BYTE1  = 8'h04;
  localparam logic [7:0] MEAS_BYTE  = 8'h01;
  localparam logic [7:0] DIGIT_MAX  = 8'h09;

  localparam logic [3:0] IDX_HDR0       = 4'd0;
  localparam logic [3:0] IDX_HDR1       = 4'd1;
  localparam logic [3:0] IDX_MODE       = 4'd2;
  localparam logic [3:0] IDX_FIRST_DIG  = 4'd3;
  localparam logic [3:0] IDX_LAST_DIG   = 4'd7;
  localparam logic [3:0] IDX_MEAS       = 4'd8;
  localparam logic [3:0] IDX_SUM        = 4'd9;

  localparam int unsigned LEVEL_W = 17;

endpackage

@@ rtl/sound_level_packet_receiver.sv @@
// A byte is taken into the input register; any result it yields is then registered in the output register.
// Throughput: one byte per cycle; the input register stalls only while a result is
// held unread in the output register.
// Reset (asynchronous, active low) returns to idle, waiting for the ready byte, with
// both pipeline registers empty. Packet bytes kept for the checks carry no reset.
`include "sound_level_packet_receiver_defines.svh"

module sound_level_packet_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  command_byte_o,
  output logic [16:0] level_tenths_o,
  output logic        hold_o,
  output logic [1:0]  freq_weight_o,
  output logic [1:0]  time_weight_o,
  output logic        over_alarm_o,
  output logic        long_average_o,
  output logic [2:0]  error_code_o
);

  localparam int unsigned LW = slpr_pkg::LEVEL_W;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // receiver state
  slpr_pkg::phase_e phase_q, phase_d;
  logic [3:0]    count_q, count_d;
  logic [7:0]    sum_q, sum_d;
  logic [LW-1:0] level_q, level_d;
  logic [7:0]    hdr0_q, hdr1_q, mode_q, meas_q;

  // output register
  logic             out_valid_q;
  slpr_pkg::kind_e  kind_q, kind_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [LW-1:0]    lvl_out_q, lvl_out_d;
  logic             hold_q, hold_d;
  logic [1:0]       fw_q, fw_d;
  logic [1:0]       tw_q, tw_d;
  logic             alarm_q, alarm_d;
  logic             lavg_q, lavg_d;
  slpr_pkg::err_e   err_q, err_d;

  logic proc;
  logic has_result;

  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  always_comb begin
    logic [3:0] mode_nib;
    logic [3:0] cfg_nib;
    logic       is_digit;
    logic [1:0] fw;
    logic [1:0] tw;
    logic       alarm;
    logic       lavg;

    phase_d    = phase_q;
    count_d    = count_q;
    sum_d      = sum_q;
    level_d    = level_q;
    has_result = 1'b0;
    kind_d     = slpr_pkg::KIND_CMD;
    cmd_d      = '0;
    lvl_out_d  = '0;
    hold_d     = 1'b0;
    fw_d       = '0;
    tw_d       = '0;
    alarm_d    = 1'b0;
    lavg_d     = 1'b0;
    err_d      = slpr_pkg::ERR_OK;

    mode_nib = mode_q[7:4];
    cfg_nib  = mode_q[3:0];
    is_digit = (in_byte_q <= slpr_pkg::DIGIT_MAX);
    fw       = '0;
    tw       = '0;
    alarm    = 1'b0;
    lavg     = 1'b0;

    // weighting decode from the config nibble
    if (cfg_nib <= 4'd5) begin
      fw = cfg_nib[2:1];
      tw = cfg_nib[0] ? 2'd2 : 2'd1;
    end else if (cfg_nib <= 4'd7) begin
      tw    = cfg_nib[0] ? 2'd2 : 2'd1;
      alarm = 1'b1;
    end else if (cfg_nib <= 4'd9) begin
      tw   = 2'd1;
      lavg = 1'b1;
    end else if (cfg_nib <= 4'd11) begin
      tw   = 2'd2;
      lavg = 1'b1;
    end else begin
      fw = 2'd2;
    end

    case (phase_q)
      slpr_pkg::PH_IDLE: begin
        if (in_byte_q == slpr_pkg::READY_BYTE) begin
          has_result = 1'b1;
          kind_d     = slpr_pkg::KIND_CMD;
          cmd_d      = slpr_pkg::CMD_BYTE;
          phase_d    = slpr_pkg::PH_COLLECT;
          count_d    = '0;
          sum_d      = '0;
          level_d    = '0;
        end
      end
      slpr_pkg::PH_COLLECT: begin
        count_d = count_q + 4'd1;
        sum_d   = sum_q + in_byte_q;
        if (count_q >= slpr_pkg::IDX_FIRST_DIG && count_q <= slpr_pkg::IDX_LAST_DIG
            && is_digit) begin
          level_d = LW'({level_q, 3'b000}) + LW'({level_q, 1'b0}) + LW'(in_byte_q);
        end
        if (count_q == slpr_pkg::IDX_SUM) begin
          has_result = 1'b1;
          phase_d    = slpr_pkg::PH_IDLE;
          count_d    = '0;
          kind_d     = slpr_pkg::KIND_REJECT;
          if (hdr0_q != slpr_pkg::HDR_BYTE0 || hdr1_q != slpr_pkg::HDR_BYTE1) begin
            err_d = slpr_pkg::ERR_HEADER;
          end else if (meas_q != slpr_pkg::MEAS_BYTE) begin
            err_d = slpr_pkg::ERR_MEAS;
          end else if (sum_q != in_byte_q) begin
            err_d = slpr_pkg::ERR_SUM;
          end else if (mode_nib != 4'd1 && mode_nib != 4'd2) begin
            err_d = slpr_pkg::ERR_MODE;
          end else if (cfg_nib > 4'd13) begin
            err_d = slpr_pkg::ERR_CFG;
          end else begin
            kind_d    = slpr_pkg::KIND_MEAS;
            lvl_out_d = level_q;
            hold_d    = (mode_nib == 4'd2);
            fw_d      = fw;
            tw_d      = tw;
            alarm_d   = alarm;
            lavg_d    = lavg;
          end
        end
      end
      default: begin
        phase_d = slpr_pkg::PH_IDLE;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= slpr_pkg::PH_IDLE;
      count_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (proc) begin
        phase_q <= phase_d;
        count_q <= count_d;
      end
      if (proc && has_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (proc) begin
      sum_q   <= sum_d;
      level_q <= level_d;
      if (phase_q == slpr_pkg::PH_COLLECT) begin
        case (count_q)
          slpr_pkg::IDX_HDR0: hdr0_q <= in_byte_q;
          slpr_pkg::IDX_HDR1: hdr1_q <= in_byte_q;
          slpr_pkg::IDX_MODE: mode_q <= in_byte_q;
          slpr_pkg::IDX_MEAS: meas_q <= in_byte_q;
          default: ;
        endcase
      end
    end
    if (proc && has_result) begin
      kind_q    <= kind_d;
      cmd_q     <= cmd_d;
      lvl_out_q <= lvl_out_d;
      hold_q    <= hold_d;
      fw_q      <= fw_d;
      tw_q      <= tw_d;
      alarm_q   <= alarm_d;
      lavg_q    <= lavg_d;
      err_q     <= err_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign command_byte_o = cmd_q;
  assign level_tenths_o = lvl_out_q;
  assign hold_o         = hold_q;
  assign freq_weight_o  = fw_q;
  assign time_weight_o  = tw_q;
  assign over_alarm_o   = alarm_q;
  assign long_average_o = lavg_q;
  assign error_code_o   = err_q;

  `SLPR_ASSERT(a_count_range, count_q <= slpr_pkg::IDX_SUM)
  `SLPR_ASSERT(a_idle_count_zero, phase_q == slpr_pkg::PH_IDLE |-> count_q == 4'd0)
  `SLPR_ASSERT(a_cmd_fields, out_valid_q && kind_q == slpr_pkg::KIND_CMD |-> cmd_q == slpr_pkg::CMD_BYTE && err_q == slpr_pkg::ERR_OK)
  `SLPR_ASSERT(a_kind_err_match, out_valid_q |-> (kind_q == slpr_pkg::KIND_REJECT) == (err_q != slpr_pkg::ERR_OK))
  `SLPR_ASSERT(a_result_from_proc, $rose(out_valid_q) |-> $past(proc))
  `SLPR_ASSERT_NEVER(a_no_drop, out_valid_q && !out_ready_i && proc && has_result)

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int PKT_LEN         = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_BYTES    = 1150;
  localparam int MAX_PRINTED     = 100;

  // mode nibble, config nibble and weighting codes
  localparam logic [3:0] MODE_NORMAL  = 4'd1;
  localparam logic [3:0] MODE_HOLD    = 4'd2;
  localparam logic [3:0] CFG_FAST_C   = 4'd2;
  localparam logic [3:0] CFG_ALARM_LO = 4'd6;
  localparam logic [3:0] CFG_LAVG_LO  = 4'd8;
  localparam logic [3:0] CFG_LAVG_F9  = 4'd9;
  localparam logic [3:0] CFG_LAVG_S10 = 4'd10;
  localparam logic [3:0] CFG_CAL_LO   = 4'd12;
  localparam logic [3:0] CFG_LAST     = 4'd13;
  localparam logic [1:0] FW_A    = 2'd0;
  localparam logic [1:0] FW_FLAT = 2'd2;
  localparam logic [1:0] TW_NONE = 2'd0;
  localparam logic [1:0] TW_FAST = 2'd1;
  localparam logic [1:0] TW_SLOW = 2'd2;

  typedef logic [7:0] meter_packet_t [PKT_LEN];

  typedef struct packed {
    slpr_pkg::kind_e kind;
    logic [7:0]      command_byte;
    logic [16:0]     level;
    logic            hold;
    logic [1:0]      freq_w;
    logic [1:0]      time_w;
    logic            over_alarm;
    logic            long_average;
    slpr_pkg::err_e  err;
  } meter_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  command_byte_o;
  logic [16:0] level_tenths_o;
  logic        hold_o;
  logic [1:0]  freq_weight_o;
  logic [1:0]  time_weight_o;
  logic        over_alarm_o;
  logic        long_average_o;
  logic [2:0]  error_code_o;

  sound_level_packet_receiver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .command_byte_o (command_byte_o),
    .level_tenths_o (level_tenths_o),
    .hold_o         (hold_o),
    .freq_weight_o  (freq_weight_o),
    .time_weight_o  (time_weight_o),
    .over_alarm_o   (over_alarm_o),
    .long_average_o (long_average_o),
    .error_code_o   (error_code_o)
  );

  // predictor state
  logic          collecting = 1'b0;
  int            pkt_count  = 0;
  logic [7:0]    pkt_bytes [PKT_LEN];
  meter_result_t expected_results [$];

  int fail_count      = 0;
  bit gaps_on         = 1'b1;
  int rx_hold_cycles  = 0;
  int idle_cycles     = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic log_failure(input string msg);
    if (fail_count < MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [16:0] got,
                             input logic [16:0] want);
    if (got !== want)
      log_failure($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  function automatic logic [7:0] packet_sum(input meter_packet_t p);
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < slpr_pkg::IDX_SUM; i++) s += p[i];
    return s;
  endfunction

  function automatic meter_result_t decode_packet();
    meter_result_t r;
    logic [16:0]   lvl;
    logic [3:0]    mode;
    logic [3:0]    cfg;
    r    = '0;
    lvl  = '0;
    mode = pkt_bytes[slpr_pkg::IDX_MODE][7:4];
    cfg  = pkt_bytes[slpr_pkg::IDX_MODE][3:0];
    for (int i = slpr_pkg::IDX_FIRST_DIG; i <= slpr_pkg::IDX_LAST_DIG; i++)
      if (pkt_bytes[i] <= slpr_pkg::DIGIT_MAX) lvl = 17'(lvl * 10 + pkt_bytes[i]);
    r.kind = slpr_pkg::KIND_REJECT;
    if (pkt_bytes[slpr_pkg::IDX_HDR0] != slpr_pkg::HDR_BYTE0
        || pkt_bytes[slpr_pkg::IDX_HDR1] != slpr_pkg::HDR_BYTE1) begin
      r.err = slpr_pkg::ERR_HEADER;
    end else if (pkt_bytes[slpr_pkg::IDX_MEAS] != slpr_pkg::MEAS_BYTE) begin
      r.err = slpr_pkg::ERR_MEAS;
    end else if (packet_sum(pkt_bytes) != pkt_bytes[slpr_pkg::IDX_SUM]) begin
      r.err = slpr_pkg::ERR_SUM;
    end else if (mode != MODE_NORMAL && mode != MODE_HOLD) begin
      r.err = slpr_pkg::ERR_MODE;
    end else if (cfg > CFG_LAST) begin
      r.err = slpr_pkg::ERR_CFG;
    end else begin
      r.kind  = slpr_pkg::KIND_MEAS;
      r.err   = slpr_pkg::ERR_OK;
      r.level = lvl;
      r.hold  = (mode == MODE_HOLD);
      if (cfg < CFG_ALARM_LO) begin
        r.freq_w = cfg[2:1];
        r.time_w = cfg[0] ? TW_SLOW : TW_FAST;
      end else if (cfg < CFG_CAL_LO) begin
        r.freq_w       = FW_A;
        r.over_alarm   = (cfg < CFG_LAVG_LO);
        r.long_average = (cfg >= CFG_LAVG_LO);
        if (cfg == CFG_LAVG_LO || cfg == CFG_LAVG_F9) r.time_w = TW_FAST;
        else if (cfg >= CFG_LAVG_S10)                 r.time_w = TW_SLOW;
        else                                           r.time_w = cfg[0] ? TW_SLOW : TW_FAST;
      end else begin
        r.freq_w = FW_FLAT;
        r.time_w = TW_NONE;
      end
    end
    return r;
  endfunction

  task automatic predict_meter_byte(input logic [7:0] b);
    meter_result_t r;
    if (!collecting) begin
      if (b == slpr_pkg::READY_BYTE) begin
        r              = '0;
        r.kind         = slpr_pkg::KIND_CMD;
        r.command_byte = slpr_pkg::CMD_BYTE;
        r.err          = slpr_pkg::ERR_OK;
        expected_results.push_back(r);
        collecting = 1'b1;
        pkt_count  = 0;
      end
    end else begin
      pkt_bytes[pkt_count] = b;
      pkt_count++;
      if (pkt_count == PKT_LEN) begin
        expected_results.push_back(decode_packet());
        collecting = 1'b0;
        pkt_count  = 0;
      end
    end
  endtask

  // valid stays high across back-to-back beats; it only drops when a gap is drawn
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_meter_byte(b);
  endtask

  task automatic send_packet(input meter_packet_t p);
    send_byte(slpr_pkg::READY_BYTE);
    for (int i = 0; i < PKT_LEN; i++) send_byte(p[i]);
  endtask

  function automatic meter_packet_t random_packet();
    meter_packet_t p;
    logic [3:0]    mode;
    mode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                       : ($urandom_range(0, 1) ? MODE_HOLD : MODE_NORMAL);
    p[slpr_pkg::IDX_HDR0] = slpr_pkg::HDR_BYTE0;
    p[slpr_pkg::IDX_HDR1] = slpr_pkg::HDR_BYTE1;
    p[slpr_pkg::IDX_MODE] = {mode, 4'($urandom_range(0, 15))};
    for (int i = slpr_pkg::IDX_FIRST_DIG; i <= slpr_pkg::IDX_LAST_DIG; i++)
      p[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
    p[slpr_pkg::IDX_MEAS] = slpr_pkg::MEAS_BYTE;
    if ($urandom_range(0, 15) == 0) p[$urandom_range(0, 1)] = 8'($urandom);
    if ($urandom_range(0, 15) == 0) p[slpr_pkg::IDX_MEAS] = 8'($urandom);
    p[slpr_pkg::IDX_SUM] = packet_sum(p);
    if ($urandom_range(0, 15) == 0) p[slpr_pkg::IDX_SUM] = 8'($urandom);
    // now and then a packet of pure noise
    if ($urandom_range(0, 19) == 0)
      for (int i = 0; i < PKT_LEN; i++) p[i] = 8'($urandom);
    return p;
  endfunction

  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(8'hff);
  endtask

  task automatic test_full_scale_packet();
    meter_packet_t p;
    p = '{slpr_pkg::HDR_BYTE0, slpr_pkg::HDR_BYTE1, {MODE_HOLD, CFG_CAL_LO},
          8'd9, 8'd9, 8'd9, 8'd9, 8'd9, slpr_pkg::MEAS_BYTE, 8'h00};
    p[slpr_pkg::IDX_SUM] = packet_sum(p);
    send_packet(p);
  endtask

  task automatic test_header_reject();
    meter_packet_t p;
    p = '{slpr_pkg::HDR_BYTE0, 8'h05, {MODE_NORMAL, CFG_FAST_C},
          8'd0, 8'hff, 8'd0, 8'd1, 8'd2, slpr_pkg::MEAS_BYTE, 8'h00};
    p[slpr_pkg::IDX_SUM] = packet_sum(p);
    send_packet(p);
  endtask

  task automatic test_random_packets();
    int sent;
    int noise;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      // line noise while idle
      noise = $urandom_range(0, 2);
      repeat (noise) send_byte(8'($urandom));
      send_packet(random_packet());
      sent += PKT_LEN + 1 + noise;
    end
    gaps_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps pushing, so the input side backs up
  task automatic test_backpressure();
    gaps_on        = 1'b0;
    rx_hold_cycles = HOLD_OFF_CYCLES;
    repeat (5) send_packet(random_packet());
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_bytes();
    test_full_scale_packet();
    test_header_reject();
    test_random_packets();
    test_backpressure();
    in_valid_i <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      stall = gaps_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    meter_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        log_failure($sformatf("unexpected result, kind %0d", kind_o));
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 17'(kind_o), 17'(want.kind));
        check_field("command_byte", 17'(command_byte_o), 17'(want.command_byte));
        check_field("level_tenths", level_tenths_o, want.level);
        check_field("hold", 17'(hold_o), 17'(want.hold));
        check_field("freq_weight", 17'(freq_weight_o), 17'(want.freq_w));
        check_field("time_weight", 17'(time_weight_o), 17'(want.time_w));
        check_field("over_alarm", 17'(over_alarm_o), 17'(want.over_alarm));
        check_field("long_average", 17'(long_average_o), 17'(want.long_average));
        check_field("error_code", 17'(error_code_o), 17'(want.err));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ sound_level_packet_receiver.f @@
+incdir+rtl
rtl/slpr_pkg.sv
rtl/sound_level_packet_receiver.sv
verif/tb.sv
